// ===== rtl/greedy_nearest_chain_order_assert.svh =====
// Assertion macros shared by the RTL of the greedy nearest chain orderer.
`ifndef GREEDY_NEAREST_CHAIN_ORDER_ASSERT_SVH
`define GREEDY_NEAREST_CHAIN_ORDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GNCO_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gnco assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GNCO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gnco assertion failed");

`endif

// ===== rtl/gnco_pkg.sv =====
// Package with the shared constants and the helper function of the chain orderer.
`timescale 1ns / 1ps
package gnco_pkg;
    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int COORD_BITS_DEF   = 10;
    localparam int COORD_BITS_MAX   = 12;
    localparam int REACH_W          = 27;
    localparam logic [REACH_W-1:0] REACH_RESET = 27'd100000000;

    function automatic logic [COORD_BITS_MAX-1:0] abs_diff(
        input logic [COORD_BITS_MAX-1:0] a,
        input logic [COORD_BITS_MAX-1:0] b
    );
        logic [COORD_BITS_MAX-1:0] r;
        if (a > b) begin
            r = a - b;
        end else begin
            r = b - a;
        end
        return r;
    endfunction
endpackage

// ===== rtl/gnco_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gnco_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/gnco_dist.sv =====
// Two-stage pipelined squared distance unit between an end point and a start point.
`timescale 1ns / 1ps
module gnco_dist #(
    parameter int COORD_BITS = 10,
    parameter int IDX_W      = 6
) (
    input  logic                    clk,
    input  logic                    rstn,
    input  logic                    in_valid,
    input  logic [IDX_W-1:0]        in_idx,
    input  logic [2*COORD_BITS-1:0] end_pt,
    input  logic [2*COORD_BITS-1:0] start_pt,
    output logic                    out_valid,
    output logic [IDX_W-1:0]        out_idx,
    output logic [2*COORD_BITS:0]   out_dist,
    output logic [2*COORD_BITS-1:0] out_start
);
    import gnco_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 1;

    logic [COORD_BITS-1:0]   dx;
    logic [COORD_BITS-1:0]   dy;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic                    v1_reg;
    logic [IDX_W-1:0]        idx1_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    v2_reg;
    logic [IDX_W-1:0]        idx2_reg;
    logic [2*COORD_BITS-1:0] pt1_reg;
    logic [2*COORD_BITS-1:0] pt2_reg;

    assign dx = COORD_BITS'(abs_diff(COORD_BITS_MAX'(end_pt[COORD_BITS-1:0]),
                                     COORD_BITS_MAX'(start_pt[COORD_BITS-1:0])));
    assign dy = COORD_BITS'(abs_diff(COORD_BITS_MAX'(end_pt[2*COORD_BITS-1:COORD_BITS]),
                                     COORD_BITS_MAX'(start_pt[2*COORD_BITS-1:COORD_BITS])));

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk) begin
        sqx_reg  <= SQ_W'(dx) * SQ_W'(dx);
        sqy_reg  <= SQ_W'(dy) * SQ_W'(dy);
        idx1_reg <= in_idx;
        pt1_reg  <= start_pt;
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        idx2_reg <= idx1_reg;
        pt2_reg  <= pt1_reg;
    end

    assign out_valid = v2_reg;
    assign out_idx   = idx2_reg;
    assign out_dist  = dist_reg;
    assign out_start = pt2_reg;
endmodule

// ===== rtl/greedy_nearest_chain_order.sv =====
// Top level of the greedy nearest chain orderer: load sequencer, scan control and output register.
//
// Usage: segments arrive on the s_ channel, one item per segment, with start and end
// points. Each accepted item is written to the start and end RAMs at the next free index;
// items beyond MAX_SEGMENTS are dropped. The start RAM also keeps a visited
// mark per segment, written clear as the segment loads, except for segment 0, where every
// chain begins. The item with s_final_segment set ends the set and starts ordering; s_ready
// stays low until the whole chain is issued.
// The chain begins at segment 0. Each chain step reads the current end point, scans all
// N loaded start points and marks through the RAM read port and a two-stage distance
// pipeline, and keeps the nearest unvisited one below the reach limit (lowest index on
// ties), whose mark is then set. The scan makes one start RAM read per cycle, and the
// steps run in order: end point read, scan, pipeline drain and result put. The m_ channel
// has an output register: the next scan runs while a result waits, and a stalled receiver
// holds the block only when the following result is ready.
// The last result of a chain carries m_order_done. Afterwards the block clears its set
// state and accepts a new set. Reset clears the control state and sets the reach limit to
// its default; the RAMs need no clearing. The reach limit is written through cfg_we and
// cfg_wdata; the user writes it only while the block is idle, which the block does not enforce.
`timescale 1ns / 1ps
`include "greedy_nearest_chain_order_assert.svh"
module greedy_nearest_chain_order #(
    parameter int MAX_SEGMENTS = gnco_pkg::MAX_SEGMENTS_DEF,
    parameter int COORD_BITS   = gnco_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [gnco_pkg::REACH_W-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [COORD_BITS-1:0]           s_seg_start_x,
    input  logic [COORD_BITS-1:0]           s_seg_start_y,
    input  logic [COORD_BITS-1:0]           s_seg_end_x,
    input  logic [COORD_BITS-1:0]           s_seg_end_y,
    input  logic                            s_final_segment,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [$clog2(MAX_SEGMENTS)-1:0] m_order_entry,
    output logic                            m_order_done
);
    import gnco_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SEGMENTS);
    localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int PT_W   = 2 * COORD_BITS;
    localparam int DIST_W = 2 * COORD_BITS + 1;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_ENDRD = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_PUT   = 3'd4;

    localparam logic [1:0] DRAIN_LAST = 2'd2;

    logic [2:0]              state_reg, state_next;
    logic [CNT_W-1:0]        loaded_reg, loaded_next;
    logic [IDX_W-1:0]        cur_reg, cur_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [1:0]              drain_reg, drain_next;
    logic [REACH_W-1:0]      best_reg, best_next;
    logic [IDX_W-1:0]        near_reg, near_next;
    logic [PT_W-1:0]         near_pt_reg, near_pt_next;
    logic                    found_reg, found_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]        m_entry_reg, m_entry_next;
    logic                    m_done_reg, m_done_next;
    logic [REACH_W-1:0]      reach_reg;

    logic              accept;
    logic              out_free;
    logic              store;
    logic              mark_we;
    logic              chain_end;
    logic              start_we;
    logic [IDX_W-1:0]  start_waddr;
    logic [PT_W:0]     start_wdata;
    logic [PT_W-1:0]   end_wdata;
    logic [PT_W:0]     start_rdata;
    logic [PT_W-1:0]   end_rdata;
    logic              start_re;
    logic              end_re;
    logic              scan_valid;
    logic              dist_valid;
    logic [IDX_W-1:0]  dist_idx;
    logic [DIST_W-1:0] dist_val;
    logic [PT_W-1:0]   dist_start;
    logic              closer;

    assign s_ready     = (state_reg == ST_LOAD);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign store       = accept && (loaded_reg < CNT_W'(MAX_SEGMENTS));
    assign mark_we     = (state_reg == ST_PUT) && out_free && found_reg;
    assign chain_end   = (state_reg == ST_PUT) && out_free && !found_reg;
    assign start_we    = store || mark_we;
    assign start_waddr = store ? loaded_reg[IDX_W-1:0] : near_reg;
    assign start_wdata = store ? {(loaded_reg == '0), s_seg_start_y, s_seg_start_x}
                               : {1'b1, near_pt_reg};
    assign end_wdata   = {s_seg_end_y, s_seg_end_x};
    assign start_re    = (state_reg == ST_SCAN);
    assign end_re      = (state_reg == ST_ENDRD);
    assign scan_valid  = rd_valid_reg && !start_rdata[PT_W];
    assign closer      = dist_valid && (REACH_W'(dist_val) < best_reg);

    gnco_ram #(.WIDTH(PT_W + 1), .DEPTH(MAX_SEGMENTS)) u_start_ram (
        .clk   (aclk),
        .we    (start_we),
        .waddr (start_waddr),
        .wdata (start_wdata),
        .re    (start_re),
        .raddr (idx_reg),
        .rdata (start_rdata)
    );

    gnco_ram #(.WIDTH(PT_W), .DEPTH(MAX_SEGMENTS)) u_end_ram (
        .clk   (aclk),
        .we    (store),
        .waddr (loaded_reg[IDX_W-1:0]),
        .wdata (end_wdata),
        .re    (end_re),
        .raddr (cur_reg),
        .rdata (end_rdata)
    );

    gnco_dist #(.COORD_BITS(COORD_BITS), .IDX_W(IDX_W)) u_dist (
        .clk       (aclk),
        .rstn      (aresetn),
        .in_valid  (scan_valid),
        .in_idx    (rd_idx_reg),
        .end_pt    (end_rdata),
        .start_pt  (start_rdata[PT_W-1:0]),
        .out_valid (dist_valid),
        .out_idx   (dist_idx),
        .out_dist  (dist_val),
        .out_start (dist_start)
    );

    always_comb begin
        state_next    = state_reg;
        loaded_next   = loaded_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        drain_next    = drain_reg;
        best_next     = best_reg;
        near_next     = near_reg;
        near_pt_next  = near_pt_reg;
        found_next    = found_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_entry_next  = m_entry_reg;
        m_done_next   = m_done_reg;

        if (closer) begin
            best_next    = REACH_W'(dist_val);
            near_next    = dist_idx;
            near_pt_next = dist_start;
            found_next   = 1'b1;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (store) begin
                    loaded_next = loaded_reg + CNT_W'(1);
                end
                if (accept && s_final_segment) begin
                    cur_next   = '0;
                    state_next = ST_ENDRD;
                end
            end
            ST_ENDRD: begin
                idx_next   = '0;
                best_next  = reach_reg;
                found_next = 1'b0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                rd_valid_next = 1'b1;
                if (CNT_W'(idx_reg) + CNT_W'(1) == loaded_reg) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 2'd1;
                if (drain_reg == DRAIN_LAST) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_entry_next = cur_reg;
                    m_done_next  = !found_reg;
                    if (found_reg) begin
                        cur_next   = near_reg;
                        state_next = ST_ENDRD;
                    end else begin
                        loaded_next = '0;
                        cur_next    = '0;
                        best_next   = reach_reg;
                        state_next  = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            loaded_reg   <= '0;
            cur_reg      <= '0;
            drain_reg    <= '0;
            best_reg     <= REACH_RESET;
            found_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            reach_reg    <= REACH_RESET;
        end else begin
            state_reg    <= state_next;
            loaded_reg   <= loaded_next;
            cur_reg      <= cur_next;
            drain_reg    <= drain_next;
            best_reg     <= best_next;
            found_reg    <= found_next;
            rd_valid_reg <= rd_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_we) begin
                reach_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        near_reg    <= near_next;
        near_pt_reg <= near_pt_next;
        rd_idx_reg  <= rd_idx_next;
        m_entry_reg <= m_entry_next;
        m_done_reg  <= m_done_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_order_entry = m_entry_reg;
    assign m_order_done  = m_done_reg;

    `GNCO_ASSERT_IMPLY(a_scan_nonempty, aclk, aresetn, state_reg == ST_SCAN, loaded_reg != '0)
    `GNCO_ASSERT_IMPLY(a_scan_in_range, aclk, aresetn, start_re, CNT_W'(idx_reg) < loaded_reg)
    `GNCO_ASSERT_IMPLY(a_near_not_cur, aclk, aresetn, mark_we, near_reg != cur_reg)
    `GNCO_ASSERT_NEXT(a_chain_clear, aclk, aresetn, chain_end, loaded_reg == '0 && m_order_done)
endmodule
